// ===== design/vcc_pkg.sv =====
// ----------------------------------------------------------------------------
// vcc_pkg : shared types and constants for the velocity constraint cost
// Field widths, configuration record, register indexes and state encodings.
// ----------------------------------------------------------------------------
package vcc_pkg;

  localparam int VEL_W   = 16;
  localparam int PEN_W   = 18;
  localparam int TERM_W  = 26;
  localparam int SUM_W   = 40;
  localparam int COST_W  = 48;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  localparam int MAX_POWER_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam logic [COST_W-1:0] ONE_Q16  = COST_W'(65536);

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE    = 3'd0,
    REG_ACKERMANN = 3'd1,
    REG_MIN_TURN  = 3'd2,
    REG_MAX_SPEED = 3'd3,
    REG_MIN_SPEED = 3'd4,
    REG_STEP_TIME = 3'd5,
    REG_WEIGHT    = 3'd6,
    REG_POWER     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        enable;
    logic        ackermann_mode;
    logic [15:0] min_turn_radius;
    logic [15:0] max_speed;
    logic [15:0] min_speed;
    logic [15:0] step_time;
    logic [15:0] weight;
    logic [2:0]  power;
  } cfg_t;

  typedef struct packed {
    logic [TERM_W-1:0] term;
    logic              last;
  } step_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQ, F_SUMSQ, F_ITER, F_PEN, F_TERM
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_WEIGHT, B_MUL, B_OUT
  } back_state_t;

endpackage

// ===== design/vcc_in_if.sv =====
// ----------------------------------------------------------------------------
// vcc_in_if : trajectory step channel
// Valid/ready channel carrying one time step of a sampled trajectory.
// ----------------------------------------------------------------------------
interface vcc_in_if import vcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VEL_W-1:0] vel_x;
  logic [VEL_W-1:0] vel_y;
  logic [VEL_W-1:0] yaw_rate;
  logic             last;

  modport source (output valid, vel_x, vel_y, yaw_rate, last, input ready);
  modport sink   (input valid, vel_x, vel_y, yaw_rate, last, output ready);
endinterface

// ===== design/vcc_out_if.sv =====
// ----------------------------------------------------------------------------
// vcc_out_if : trajectory cost channel
// Valid/ready channel carrying one cost result per trajectory.
// ----------------------------------------------------------------------------
interface vcc_out_if import vcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;
  logic              saturated;

  modport source (output valid, cost, saturated, input ready);
  modport sink   (input valid, cost, saturated, output ready);
endinterface

// ===== design/vcc_front.sv =====
// ----------------------------------------------------------------------------
// vcc_front : per-step penalty front end
// Iterative square root and divider, penalty forming and step time scaling.
// ----------------------------------------------------------------------------
module vcc_front import vcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  vcc_in_if.sink      in_ch,
  output logic        push_valid,
  input  logic        push_ready,
  output step_t       push_data
);

  front_state_t state, state_next;

  logic [15:0]       ax, ay, aw;
  logic              vx_pos, last_q;
  logic [31:0]       sq_x, sq_y;
  logic [31:0]       rem, res, bitm;
  logic [23:0]       quo;
  logic [15:0]       drem;
  logic [4:0]        cnt;
  logic [PEN_W-1:0]  pen;

  logic [31:0]       trial;
  logic [16:0]       dtrial;
  logic signed [17:0] speed, d_hi, d_lo;
  logic [PEN_W-1:0]  pen_next;
  logic [33:0]       tprod;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (in_ch.valid) state_next = F_SQ;
      F_SQ:    state_next = F_SUMSQ;
      F_SUMSQ: state_next = F_ITER;
      F_ITER:  if (cnt == 5'd23) state_next = F_PEN;
      F_PEN:   state_next = F_TERM;
      F_TERM:  if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == F_IDLE);
    push_valid  = (state == F_TERM);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  // one root step and one quotient bit per cycle
  always_comb begin
    trial  = res + bitm;
    dtrial = {drem, quo[23]};
  end

  always_comb begin
    speed = vx_pos ? $signed({2'b00, res[15:0]}) : -$signed({2'b00, res[15:0]});
    d_hi  = speed - $signed({{2{cfg.max_speed[15]}}, cfg.max_speed});
    d_lo  = $signed({{2{cfg.min_speed[15]}}, cfg.min_speed}) - speed;
    pen_next = '0;
    if (!d_hi[17] && d_hi != 18'sd0) pen_next = pen_next + PEN_W'(d_hi);
    if (!d_lo[17] && d_lo != 18'sd0) pen_next = pen_next + PEN_W'(d_lo);
    if (cfg.ackermann_mode && aw != 16'd0 && {8'd0, cfg.min_turn_radius} > quo)
      pen_next = pen_next + PEN_W'(cfg.min_turn_radius - quo[15:0]);
    tprod = pen * cfg.step_time;
    push_data.term = cfg.enable ? tprod[33:8] : '0;
    push_data.last = last_q;
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        ax     <= in_ch.vel_x[15] ? 16'(-in_ch.vel_x) : in_ch.vel_x;
        ay     <= in_ch.vel_y[15] ? 16'(-in_ch.vel_y) : in_ch.vel_y;
        aw     <= in_ch.yaw_rate[15] ? 16'(-in_ch.yaw_rate) : in_ch.yaw_rate;
        vx_pos <= !in_ch.vel_x[15] && in_ch.vel_x != '0;
        last_q <= in_ch.last;
      end
      F_SQ: begin
        sq_x <= ax * ax;
        sq_y <= ay * ay;
      end
      F_SUMSQ: begin
        rem  <= sq_x + sq_y;
        res  <= '0;
        bitm <= 32'h4000_0000;
        quo  <= {ax, 8'd0};
        drem <= '0;
        cnt  <= '0;
      end
      F_ITER: begin
        cnt <= cnt + 5'd1;
        if (cnt < 5'd16) begin
          bitm <= bitm >> 2;
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitm;
          end else begin
            res <= res >> 1;
          end
        end
        if (dtrial >= {1'b0, aw}) begin
          drem <= 16'(dtrial - {1'b0, aw});
          quo  <= {quo[22:0], 1'b1};
        end else begin
          drem <= dtrial[15:0];
          quo  <= {quo[22:0], 1'b0};
        end
      end
      F_PEN: pen <= pen_next;
      default: ;
    endcase
  end

endmodule

// ===== design/vcc_queue.sv =====
// ----------------------------------------------------------------------------
// vcc_queue : step term queue
// Small FIFO between the penalty front end and the accumulator.
// ----------------------------------------------------------------------------
module vcc_queue import vcc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  step_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output step_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  step_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  always_comb begin
    push_ready = (count != CW'(DEPTH));
    pop_valid  = (count != '0);
    pop_data   = mem[rd_ptr];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

// ===== design/vcc_back.sv =====
// ----------------------------------------------------------------------------
// vcc_back : accumulator and cost back end
// Saturating penalty sum, weighting and power by a 48x16 multiply sequence.
// ----------------------------------------------------------------------------
module vcc_back import vcc_pkg::*; #(
  parameter int MAX_POWER = MAX_POWER_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   pop_valid,
  output logic   pop_ready,
  input  step_t  pop_data,
  vcc_out_if.source out_ch
);

  localparam int PCW = $clog2(MAX_POWER + 1);

  back_state_t state, state_next;

  logic [SUM_W-1:0]  sum;
  logic              sat_seen;
  logic [COST_W-1:0] xw, cost_r;
  logic              sat_r;
  logic [95:0]       acc;
  logic [1:0]        chunk;
  logic [PCW-1:0]    pcnt, p_eff;

  logic [SUM_W:0]    sum_add;
  logic [55:0]       wprod;
  logic [63:0]       part;
  logic [95:0]       acc_next;

  always_comb begin
    p_eff    = (int'(cfg.power) > MAX_POWER) ? PCW'(MAX_POWER) : PCW'(cfg.power);
    sum_add  = {1'b0, sum} + (SUM_W + 1)'(pop_data.term);
    wprod    = sum * cfg.weight;
    part     = cost_r * xw[{chunk, 4'b0000} +: 16];
    acc_next = acc + ({32'd0, part} << {chunk, 4'b0000});
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:
        if (pop_valid && pop_data.last) state_next = cfg.enable ? B_WEIGHT : B_OUT;
      B_WEIGHT: state_next = (p_eff == '0) ? B_OUT : B_MUL;
      B_MUL:    if (chunk == 2'd2 && pcnt == PCW'(1)) state_next = B_OUT;
      B_OUT:    if (out_ch.ready) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready        = (state == B_IDLE);
    out_ch.valid     = (state == B_OUT);
    out_ch.cost      = cost_r;
    out_ch.saturated = sat_r;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      sat_seen <= 1'b0;
    end else if (state == B_OUT) begin
      sum      <= '0;
      sat_seen <= 1'b0;
    end else if (state == B_IDLE && pop_valid) begin
      if (sum_add > {1'b0, SUM_MAX}) begin
        sum      <= SUM_MAX;
        sat_seen <= 1'b1;
      end else begin
        sum <= sum_add[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cost_r <= '0;
        sat_r  <= 1'b0;
      end
      B_WEIGHT: begin
        xw     <= wprod[55:8];
        cost_r <= cfg.enable ? ONE_Q16 : '0;
        sat_r  <= sat_seen;
        pcnt   <= p_eff;
        chunk  <= '0;
        acc    <= '0;
      end
      B_MUL: begin
        if (chunk == 2'd2) begin
          chunk <= '0;
          acc   <= '0;
          pcnt  <= pcnt - PCW'(1);
          if (acc_next[95:64] != '0) begin
            cost_r <= COST_MAX;
            sat_r  <= 1'b1;
          end else begin
            cost_r <= acc_next[63:16];
          end
        end else begin
          chunk <= chunk + 2'd1;
          acc   <= acc_next;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/velocity_constraint_cost.sv =====
// ----------------------------------------------------------------------------
// velocity_constraint_cost : trajectory velocity constraint critic
// Streams trajectory steps, accumulates scaled penalties, emits one cost.
// ----------------------------------------------------------------------------
// Flow: the front end takes a new step only after it has pushed the previous
//   term; root and quotient share one iteration, the root finishing first.
// Path: square, iterate, penalise and scale, queue, accumulate; a last step
//   is then weighted and raised, one chunked multiply per power stage.
// Reset: config registers and state machines reset; sum and queue clear at once.
// ----------------------------------------------------------------------------
module velocity_constraint_cost import vcc_pkg::*; #(
  parameter int MAX_POWER   = MAX_POWER_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  vcc_in_if.sink           in_ch,
  vcc_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  step_t push_data, pop_data;

  // Configuration registers: the user writes them only while the block is idle
  // (the block itself does not enforce it), so both halves read them live.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b1;
      cfg.ackermann_mode  <= 1'b0;
      cfg.min_turn_radius <= 16'd0;
      cfg.max_speed       <= 16'd256;
      cfg.min_speed       <= 16'hFF00;
      cfg.step_time       <= 16'd3277;
      cfg.weight          <= 16'd256;
      cfg.power           <= 3'd1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE:    cfg.enable          <= cfg_data[0];
        REG_ACKERMANN: cfg.ackermann_mode  <= cfg_data[0];
        REG_MIN_TURN:  cfg.min_turn_radius <= cfg_data;
        REG_MAX_SPEED: cfg.max_speed       <= cfg_data;
        REG_MIN_SPEED: cfg.min_speed       <= cfg_data;
        REG_STEP_TIME: cfg.step_time       <= cfg_data;
        REG_WEIGHT:    cfg.weight          <= cfg_data;
        REG_POWER:     cfg.power           <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Front end: take a transaction, form the step penalty term.
  vcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple: hold finished terms while the back end is busy with a result.
  vcc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: accumulate, and on the last step weight, raise and emit (zero when disabled).
  vcc_back #(.MAX_POWER(MAX_POWER)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
